/* rtl/svh_pkg.sv */
// ----------------------------------------------------------------------------
// svh_pkg: shared types and constants of the sample value histogram
// Field widths, register indexes, request codes and the record that moves
// from the front end through the queue to the bin store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svh_pkg;

  // Fixed widths of the request and result fields
  localparam int SAMPLE_BITS      = 16;
  localparam int INDEX_FIELD_BITS = 16;
  localparam int COUNT_FIELD_BITS = 64;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_SAMPLES   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_SAMPLES = 2'd1;

  // Request codes
  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Queue between front end and bin store
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // Sample format, held in the top level
  typedef struct packed {
    logic wide_samples;
    logic signed_samples;
  } cfg_t;

  // Classified request: operation and the bin it touches
  typedef struct packed {
    logic                        mode;
    logic [INDEX_FIELD_BITS-1:0] bin;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/svh_front.sv */
// ----------------------------------------------------------------------------
// svh_front: request intake and bin classification
// Takes one request, maps a sample to its bin (width select, sign bias,
// table wrap) and holds the result in one stage until the queue takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svh_front #(
  parameter int BIN_INDEX_BITS = 16
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire svh_pkg::cfg_t                     cfg,
  input  wire                                    clear_busy,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire                                    mode,
  input  wire [svh_pkg::SAMPLE_BITS-1:0]         sample_bits,
  input  wire [svh_pkg::INDEX_FIELD_BITS-1:0]    bin_select,
  output logic                                   push,
  output svh_pkg::entry_t                        push_entry,
  input  wire                                    queue_full
);
  import svh_pkg::*;

  localparam logic [INDEX_FIELD_BITS-1:0] IDX_MASK =
    INDEX_FIELD_BITS'((32'd1 << BIN_INDEX_BITS) - 32'd1);

  logic                        stage_valid;
  entry_t                      stage;
  logic                        accept;
  logic [INDEX_FIELD_BITS-1:0] sample_bin;
  entry_t                      classified;

  // Sample to bin: top bit flipped for signed data, high byte dropped in 8-bit mode
  always_comb begin
    if (cfg.wide_samples) begin
      sample_bin = sample_bits ^ {cfg.signed_samples, 15'd0};
    end else begin
      sample_bin = {8'd0, sample_bits[7:0] ^ {cfg.signed_samples, 7'd0}};
    end
    classified.mode = mode;
    if (mode == MODE_READ) begin
      classified.bin = bin_select & IDX_MASK;
    end else begin
      classified.bin = sample_bin & IDX_MASK;
    end
  end

  // Handshake: the stage frees up when the queue takes its entry
  assign push     = stage_valid && !queue_full;
  assign in_stall = clear_busy || (stage_valid && queue_full);
  assign accept   = in_valid && !in_stall;
  assign push_entry = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= classified;
    end
  end

endmodule

`default_nettype wire

/* rtl/svh_queue.sv */
// ----------------------------------------------------------------------------
// svh_queue: short request queue
// Register FIFO that decouples request intake from the bin store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svh_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire svh_pkg::entry_t  push_entry,
  input  wire                   pop,
  output svh_pkg::entry_t       head_entry,
  output logic                  empty,
  output logic                  full
);
  import svh_pkg::*;

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;

  assign empty      = (fill == '0);
  assign full       = (fill == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_entry = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue fill level above depth");
`endif

endmodule

`default_nettype wire

/* rtl/svh_back.sv */
// ----------------------------------------------------------------------------
// svh_back: bin store and read-modify-write engine
// Clears the bin memory after reset, then takes queued requests: a count
// request increments its bin, a read request returns the bin's count
// through the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svh_back #(
  parameter int BIN_INDEX_BITS = 16,
  parameter int COUNT_BITS     = 64
) (
  input  wire                                    clk,
  input  wire                                    rst,
  output logic                                   clear_busy,
  input  wire svh_pkg::entry_t                   head_entry,
  input  wire                                    queue_empty,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [svh_pkg::INDEX_FIELD_BITS-1:0]   bin_index,
  output logic [svh_pkg::COUNT_FIELD_BITS-1:0]   bin_count
);
  import svh_pkg::*;

  localparam int BIN_DEPTH = 1 << BIN_INDEX_BITS;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [COUNT_BITS-1:0]     mem [BIN_DEPTH];
  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [BIN_INDEX_BITS-1:0] clear_addr;
  logic                      cur_mode;
  logic [BIN_INDEX_BITS-1:0] cur_bin;
  logic [COUNT_BITS-1:0]     rd_data;
  logic                      mem_we;
  logic [BIN_INDEX_BITS-1:0] mem_waddr;
  logic [COUNT_BITS-1:0]     mem_wdata;
  logic                      out_free;
  logic                      out_load;

  assign clear_busy = (state == ST_CLEAR);
  assign out_free   = !out_valid || !out_stall;
  assign pop        = (state == ST_IDLE) && !queue_empty;
  assign out_load   = (state == ST_UPDATE) && (cur_mode == MODE_READ) && out_free;

  // Sequencer: clear sweep, then fetch and update one request at a time
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur_bin;
    mem_wdata  = rd_data + COUNT_BITS'(1);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (cur_mode == MODE_COUNT) begin
          mem_we     = 1'b1;
          state_next = ST_IDLE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data <= mem[head_entry.bin[BIN_INDEX_BITS-1:0]];
    end
  end

  // Request being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mode <= head_entry.mode;
      cur_bin  <= head_entry.bin[BIN_INDEX_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_index <= INDEX_FIELD_BITS'(cur_bin);
      bin_count <= COUNT_FIELD_BITS'(rd_data);
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_empty)
    else $error("pop from empty queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !pop)
    else $error("request taken during clear sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bin_count) && $stable(bin_index)))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

/* rtl/sample_value_histogram.sv */
// ----------------------------------------------------------------------------
// sample_value_histogram: sample value histogram with signed bias
// Counts occurrences of each sample value in a table of wrapping counters;
// read requests return one bin's count.
//
//   Channel   Dir  Handshake              Payload
//   input     in   in_valid / in_stall    mode, sample_bits, bin_select,
//                                         last_in_batch
//   output    out  out_valid / out_stall  bin_index, bin_count
//   config    in   cfg_write              cfg_index, cfg_data
//
// In the bin store a request is a memory read, then a write (count) or an
// output load (read), which waits for a free output register; the
// read-modify-write on the bin memory, with no forwarding between requests,
// sets the rate, one request at a time. Intake and a 4-entry queue run ahead.
// After reset a clear sweep zeroes every bin of the memory; in_stall is high
// while it runs, config writes are taken throughout.
// A stalled output holds its result; read requests wait behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_value_histogram #(
  parameter int BIN_INDEX_BITS = 16,
  parameter int COUNT_BITS     = 64
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write,
  input  wire [svh_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire                                    cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire                                    mode,
  input  wire [svh_pkg::SAMPLE_BITS-1:0]         sample_bits,
  input  wire [svh_pkg::INDEX_FIELD_BITS-1:0]    bin_select,
  input  wire                                    last_in_batch,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [svh_pkg::INDEX_FIELD_BITS-1:0]   bin_index,
  output logic [svh_pkg::COUNT_FIELD_BITS-1:0]   bin_count
);
  import svh_pkg::*;

  cfg_t   cfg;
  logic   clear_busy;
  logic   push;
  entry_t push_entry;
  entry_t head_entry;
  logic   pop;
  logic   queue_empty;
  logic   queue_full;

  // Configuration registers; last_in_batch is a software marker with no effect
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDE_SAMPLES:   cfg.wide_samples   <= cfg_data;
        REG_SIGNED_SAMPLES: cfg.signed_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  svh_front #(
    .BIN_INDEX_BITS(BIN_INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clear_busy (clear_busy),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .sample_bits(sample_bits),
    .bin_select (bin_select),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  svh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  svh_back #(
    .BIN_INDEX_BITS(BIN_INDEX_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clear_busy  (clear_busy),
    .head_entry  (head_entry),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .bin_count   (bin_count)
  );

endmodule

`default_nettype wire

/* test/svh_bin_checker.sv */
// ----------------------------------------------------------------------------
// svh_bin_checker: scoreboard for the sample value histogram
// Watches the config port and both channels. Each accepted count updates
// a private copy of the bin table; read requests queue the expected result,
// which is compared field by field with each result the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svh_bin_checker (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire [svh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire                                  cfg_data,
  input  wire                                  in_valid,
  input  wire                                  in_stall,
  input  wire                                  mode,
  input  wire [svh_pkg::SAMPLE_BITS-1:0]       sample_bits,
  input  wire [svh_pkg::INDEX_FIELD_BITS-1:0]  bin_select,
  input  wire                                  out_valid,
  input  wire                                  out_stall,
  input  wire [svh_pkg::INDEX_FIELD_BITS-1:0]  bin_index,
  input  wire [svh_pkg::COUNT_FIELD_BITS-1:0]  bin_count,
  output int                                   pending,
  output int                                   fail_count
);
  import svh_pkg::*;

  localparam int BIN_DEPTH = 1 << INDEX_FIELD_BITS;

  typedef struct packed {
    logic [INDEX_FIELD_BITS-1:0] idx;
    logic [COUNT_FIELD_BITS-1:0] count;
  } bin_report_t;

  // Private copy of the bin table and sample format
  bit [COUNT_FIELD_BITS-1:0] bin_tally [0:BIN_DEPTH-1];
  bin_report_t               awaited_reports [$];
  logic                      fmt_wide;
  logic                      fmt_signed;

  initial begin
    pending    = 0;
    fail_count = 0;
    fmt_wide   = 1'b0;
    fmt_signed = 1'b0;
  end

  // Map a raw sample to its bin: signed samples get their top bit flipped
  function automatic logic [INDEX_FIELD_BITS-1:0] bin_of_sample(
    input logic [SAMPLE_BITS-1:0] raw, input logic wide, input logic sgn);
    logic [INDEX_FIELD_BITS-1:0] v;
    if (wide) begin
      v = raw;
      if (sgn) v[15] = ~v[15];
    end else begin
      v = {8'h00, raw[7:0]};
      if (sgn) v[7] = ~v[7];
    end
    return v;
  endfunction

  always @(posedge clk) begin : track
    bin_report_t                 want;
    logic [INDEX_FIELD_BITS-1:0] b;
    if (rst) begin
      fmt_wide   = 1'b0;
      fmt_signed = 1'b0;
      for (int i = 0; i < BIN_DEPTH; i++) bin_tally[i[INDEX_FIELD_BITS-1:0]] = '0;
      awaited_reports.delete();
    end else begin
      // Accepted request: count a sample or queue the bin it reads
      if (in_valid && !in_stall) begin
        if (mode == MODE_COUNT) begin
          b = bin_of_sample(sample_bits, fmt_wide, fmt_signed);
          bin_tally[b] = bin_tally[b] + 1'b1;
        end else begin
          want.idx   = bin_select;
          want.count = bin_tally[bin_select];
          awaited_reports.push_back(want);
        end
      end

      // Delivered result against the oldest expectation
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result bin_index=%h bin_count=%h",
                   $time, bin_index, bin_count);
          fail_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (bin_index !== want.idx) begin
            $display("%0t: bin_index mismatch: expected %h, actual %h",
                     $time, want.idx, bin_index);
            fail_count++;
          end
          if (bin_count !== want.count) begin
            $display("%0t: bin_count mismatch (bin %h): expected %h, actual %h",
                     $time, want.idx, want.count, bin_count);
            fail_count++;
          end
        end
      end

      // Register writes; spare indexes are ignored
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDE_SAMPLES:   fmt_wide   = cfg_data;
          REG_SIGNED_SAMPLES: fmt_signed = cfg_data;
          default: ;
        endcase
      end
    end
    pending = awaited_reports.size();
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the sample value histogram
// Drives a directed set of count and read requests over every sample format,
// then random phases that switch format and idling. Hot sample values keep
// counts climbing; reads mostly target those bins. The checker scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import svh_pkg::*;

  // Indexes past the two real registers
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  localparam int DRAIN_CYCLES    = 32;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 110;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic                        cfg_data = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        mode = MODE_COUNT;
  logic [SAMPLE_BITS-1:0]      sample_bits = '0;
  logic [INDEX_FIELD_BITS-1:0] bin_select = '0;
  logic                        last_in_batch = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [INDEX_FIELD_BITS-1:0] bin_index;
  logic [COUNT_FIELD_BITS-1:0] bin_count;

  int                          pending;
  int                          fail_count;
  int                          sender_idle_pct = 0;
  int                          stall_pct = 0;
  logic                        cur_wide = 1'b0;
  logic                        cur_signed = 1'b0;
  logic [SAMPLE_BITS-1:0]      hot_values [0:7];
  logic [SAMPLE_BITS-1:0]      last_sample = '0;

  always #5 clk = ~clk;

  sample_value_histogram u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sample_bits(sample_bits), .bin_select(bin_select),
    .last_in_batch(last_in_batch),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .bin_count(bin_count)
  );

  svh_bin_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sample_bits(sample_bits), .bin_select(bin_select),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .bin_count(bin_count),
    .pending(pending), .fail_count(fail_count)
  );

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  // Run timeout
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [INDEX_FIELD_BITS-1:0] bin_for_value(
    input logic [SAMPLE_BITS-1:0] v);
    if (cur_wide) return v ^ {cur_signed, 15'd0};
    return {8'd0, v[7:0] ^ {cur_signed, 7'd0}};
  endfunction

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 61; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 61; end
      default:       begin sender_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // One request: optional idle gap, then hold until accepted
  task automatic send_request(input logic m, input logic [SAMPLE_BITS-1:0] s,
                              input logic [INDEX_FIELD_BITS-1:0] sel, input logic lb);
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid      = 1'b1;
    mode          = m;
    sample_bits   = s;
    bin_select    = sel;
    last_in_batch = lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == REG_WIDE_SAMPLES) cur_wide = val;
    if (idx == REG_SIGNED_SAMPLES) cur_signed = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Wait for all reads to come back, then let trailing counts retire
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random request: mostly hot values so reads see growing counts
  task automatic random_request();
    logic                        m;
    logic [SAMPLE_BITS-1:0]      s;
    logic [SAMPLE_BITS-1:0]      hv;
    logic [INDEX_FIELD_BITS-1:0] sel;
    int                          pick;
    m  = ($urandom_range(0, 99) < 35) ? MODE_READ : MODE_COUNT;
    hv = hot_values[3'($urandom_range(0, 7))];
    pick = $urandom_range(0, 99);
    if (m == MODE_READ) begin
      s = SAMPLE_BITS'($urandom_range(0, 65535));
      if (pick < 25)      sel = INDEX_FIELD_BITS'($urandom_range(0, 65535));
      else if (pick < 40) sel = bin_for_value(last_sample);
      else                sel = bin_for_value(hv);
    end else begin
      sel = INDEX_FIELD_BITS'($urandom_range(0, 65535));
      if (pick < 20)      s = SAMPLE_BITS'($urandom_range(0, 65535));
      else if (pick < 40) s = last_sample;
      else if (cur_wide)  s = hv;
      else                s = {8'($urandom_range(0, 255)), hv[7:0]};
      last_sample = s;
    end
    send_request(m, s, sel, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    hot_values[0] = 16'h0000;
    hot_values[1] = 16'hFFFF;
    hot_values[2] = 16'h8000;
    hot_values[3] = 16'h7FFF;
    for (int i = 4; i < 8; i++) hot_values[3'(i)] = '0;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Registers are taken during the clear sweep; spare indexes do nothing
    write_reg(REG_SPARE_LO, 1'b1);
    write_reg(REG_SPARE_HI, 1'b1);
    write_reg(REG_WIDE_SAMPLES, 1'b0);
    write_reg(REG_SIGNED_SAMPLES, 1'b0);
    write_reg(REG_SPARE_HI, 1'b0);
    set_idling(IDLE_NONE);

    // 8-bit unsigned: high byte ignored, back-to-back count then read
    send_request(MODE_COUNT, 16'h0000, 16'hFFFF, 1'b0);
    send_request(MODE_COUNT, 16'hFF00, 16'h1234, 1'b1);
    send_request(MODE_COUNT, 16'hABFF, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'hFFFF, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'h00FF, 1'b1);
    send_request(MODE_READ,  16'h5555, 16'hFFFF, 1'b0);
    send_request(MODE_COUNT, 16'h00FF, 16'hAAAA, 1'b0);
    send_request(MODE_READ,  16'h00FF, 16'h00FF, 1'b1);
    settle();

    // 8-bit signed: most negative lands in bin 0
    write_reg(REG_SIGNED_SAMPLES, 1'b1);
    send_request(MODE_COUNT, 16'h0080, 16'h0000, 1'b0);
    send_request(MODE_COUNT, 16'h007F, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'h00FF, 1'b1);
    settle();

    // 16-bit signed
    write_reg(REG_WIDE_SAMPLES, 1'b1);
    send_request(MODE_COUNT, 16'h8000, 16'h0000, 1'b0);
    send_request(MODE_COUNT, 16'h7FFF, 16'h0000, 1'b0);
    send_request(MODE_COUNT, 16'h0000, 16'h0000, 1'b0);
    send_request(MODE_COUNT, 16'h0000, 16'h0000, 1'b1);
    send_request(MODE_READ,  16'h0000, 16'h8000, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'hFFFF, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'h0000, 1'b1);
    settle();

    // 16-bit unsigned
    write_reg(REG_SIGNED_SAMPLES, 1'b0);
    send_request(MODE_COUNT, 16'hFFFF, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'h0000, 16'hFFFF, 1'b1);
    send_request(MODE_COUNT, 16'h1234, 16'h0000, 1'b0);
    send_request(MODE_READ,  16'hFFFF, 16'h1234, 1'b0);

    // Random phases over all formats and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(REG_WIDE_SAMPLES, ph[0]);
      write_reg(REG_SIGNED_SAMPLES, ph[1]);
      set_idling(idle_mode_t'((ph + ph / 4) % 4));
      for (int i = 4; i < 8; i++) hot_values[3'(i)] = SAMPLE_BITS'($urandom_range(0, 65535));
      repeat (ITEMS_PER_PHASE) random_request();
    end

    settle();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
